### hw/rtl/dra_pkg.sv
`default_nettype none
package dra_pkg;

  localparam int unsigned POS_W   = 24;
  localparam int unsigned ROLL_W  = 16;
  localparam int unsigned NF_W    = 24;
  localparam int unsigned ATT_W   = 17;
  localparam int unsigned LOG_W   = 21;
  localparam int unsigned MANT_W  = 31;
  localparam int unsigned FRAC_N  = 16;
  localparam int unsigned IP_W    = 10;

  localparam logic [NF_W-1:0]  NF_RESET = 24'd16777;
  localparam logic [16:0]      SCALE    = 17'd100000;
  localparam logic [ATT_W-1:0] ONE_Q16  = 17'd65536;
  localparam logic [23:0]      D_MAX    = 24'hFFFFFF;

  function automatic logic [63:0] isqrt_c(input logic [63:0] v);
    logic [63:0] r;
    logic [63:0] b;
    logic [63:0] x;
    r = '0;
    b = 64'h4000_0000_0000_0000;
    x = v;
    for (int i = 0; i < 32; i++) begin
      if (x >= r + b) begin
        x = x - (r + b);
        r = (r >> 1) + b;
      end else begin
        r = r >> 1;
      end
      b = b >> 2;
    end
    return r;
  endfunction

  function automatic logic [63:0] exp_fac(input int n);
    logic [63:0] fac;
    fac = 64'd2 << 30;
    for (int i = 0; i < 16; i++) begin
      if (i < n) begin
        fac = isqrt_c(fac << 30);
      end
    end
    return fac;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/dra_dist.sv
`default_nettype none
module dra_dist
  import dra_pkg::*;
#(
  parameter int unsigned SW = 64
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 vld_i,
  input  wire logic signed [23:0]   sx,
  input  wire logic signed [23:0]   sy,
  input  wire logic signed [23:0]   sz,
  input  wire logic signed [23:0]   lx,
  input  wire logic signed [23:0]   ly,
  input  wire logic signed [23:0]   lz,
  input  wire logic [SW-1:0]        side_i,
  output logic                      vld_o,
  output logic [24:0]               d_o,
  output logic [SW-1:0]             side_o
);

  localparam int unsigned NB = 25;

  logic signed [24:0] dx_r, dy_r, dz_r;
  logic [48:0]        qx_r, qy_r, qz_r;
  logic [SW-1:0]      s0_r, s1_r;
  logic               v0_r, v1_r;
  logic signed [49:0] px, py, pz;

  logic [50:0]   v_r    [0:NB];
  logic [50:0]   q_r    [0:NB];
  logic [SW-1:0] side_r [0:NB];
  logic [NB:0]   vld_r;

  assign px = dx_r * dx_r;
  assign py = dy_r * dy_r;
  assign pz = dz_r * dz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      vld_r[0] <= 1'b0;
    end else if (en) begin
      v0_r <= vld_i;
      v1_r <= v0_r;
      vld_r[0] <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r <= $signed({sx[23], sx}) - $signed({lx[23], lx});
      dy_r <= $signed({sy[23], sy}) - $signed({ly[23], ly});
      dz_r <= $signed({sz[23], sz}) - $signed({lz[23], lz});
      s0_r <= side_i;
      qx_r <= px[48:0];
      qy_r <= py[48:0];
      qz_r <= pz[48:0];
      s1_r <= s0_r;
      v_r[0] <= {2'b0, qx_r} + {2'b0, qy_r} + {2'b0, qz_r};
      q_r[0] <= '0;
      side_r[0] <= s1_r;
    end
  end

  for (genvar j = 0; j < NB; j++) begin : g_sqrt
    localparam logic [50:0] B = 51'd1 << (2 * (NB - 1 - j));
    logic [50:0] tr;
    assign tr = q_r[j] + B;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        if (v_r[j] >= tr) begin
          v_r[j+1] <= v_r[j] - tr;
          q_r[j+1] <= (q_r[j] >> 1) + B;
        end else begin
          v_r[j+1] <= v_r[j];
          q_r[j+1] <= q_r[j] >> 1;
        end
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign vld_o  = vld_r[NB];
  assign d_o    = q_r[NB][24:0];
  assign side_o = side_r[NB];

endmodule
`default_nettype wire

### hw/rtl/dra_log.sv
`default_nettype none
module dra_log
  import dra_pkg::*;
#(
  parameter int unsigned SW = 42
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [23:0]       xa_i,
  input  wire logic [23:0]       xb_i,
  input  wire logic [SW-1:0]     side_i,
  output logic                   vld_o,
  output logic [LOG_W-1:0]       la_o,
  output logic [LOG_W-1:0]       lb_o,
  output logic [SW-1:0]          side_o
);

  logic [MANT_W-1:0] ma_r   [0:FRAC_N];
  logic [MANT_W-1:0] mb_r   [0:FRAC_N];
  logic [LOG_W-1:0]  ra_r   [0:FRAC_N];
  logic [LOG_W-1:0]  rb_r   [0:FRAC_N];
  logic [SW-1:0]     side_r [0:FRAC_N];
  logic [FRAC_N:0]   vld_r;
  logic [4:0]        ka, kb;

  always_comb begin
    ka = '0;
    kb = '0;
    for (int i = 0; i < 24; i++) begin
      if (xa_i[i]) ka = 5'(i);
      if (xb_i[i]) kb = 5'(i);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r[0]   <= {7'd0, xa_i} << (5'd30 - ka);
      mb_r[0]   <= {7'd0, xb_i} << (5'd30 - kb);
      ra_r[0]   <= {ka, 16'd0};
      rb_r[0]   <= {kb, 16'd0};
      side_r[0] <= side_i;
    end
  end

  for (genvar j = 0; j < FRAC_N; j++) begin : g_step
    localparam int unsigned BIT = FRAC_N - 1 - j;
    logic [61:0] sa, sb;
    logic [31:0] ta, tb;
    assign sa = ma_r[j] * ma_r[j];
    assign sb = mb_r[j] * mb_r[j];
    assign ta = sa[61:30];
    assign tb = sb[61:30];
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[j+1] <= 1'b0;
      end else if (en) begin
        vld_r[j+1] <= vld_r[j];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        ma_r[j+1]   <= ta[31] ? ta[31:1] : ta[30:0];
        mb_r[j+1]   <= tb[31] ? tb[31:1] : tb[30:0];
        ra_r[j+1]   <= ra_r[j] | (LOG_W'(ta[31]) << BIT);
        rb_r[j+1]   <= rb_r[j] | (LOG_W'(tb[31]) << BIT);
        side_r[j+1] <= side_r[j];
      end
    end
  end

  assign vld_o  = vld_r[FRAC_N];
  assign la_o   = ra_r[FRAC_N];
  assign lb_o   = rb_r[FRAC_N];
  assign side_o = side_r[FRAC_N];

endmodule
`default_nettype wire

### hw/rtl/dra_exp.sv
`default_nettype none
module dra_exp
  import dra_pkg::*;
#(
  parameter int unsigned SW = 36
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire logic              vld_i,
  input  wire logic [15:0]       f_i,
  input  wire logic [SW-1:0]     side_i,
  output logic                   vld_o,
  output logic [MANT_W-1:0]      e_o,
  output logic [SW-1:0]          side_o
);

  logic [MANT_W-1:0] e_r    [0:FRAC_N];
  logic [15:0]       f_r    [0:FRAC_N];
  logic [SW-1:0]     side_r [0:FRAC_N];
  logic [FRAC_N:0]   vld_r;

  always_comb begin
    vld_r[0]  = vld_i;
    e_r[0]    = 31'h4000_0000;
    f_r[0]    = f_i;
    side_r[0] = side_i;
  end

  for (genvar k = 0; k < FRAC_N; k++) begin : g_step
    localparam logic [MANT_W-1:0] FAC = MANT_W'(exp_fac(k + 1));
    logic [61:0] pr;
    assign pr = e_r[k] * FAC;
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k+1] <= 1'b0;
      end else if (en) begin
        vld_r[k+1] <= vld_r[k];
      end
    end
    always_ff @(posedge clk) begin
      if (en) begin
        e_r[k+1]    <= f_r[k][FRAC_N-1-k] ? pr[60:30] : e_r[k];
        f_r[k+1]    <= f_r[k];
        side_r[k+1] <= side_r[k];
      end
    end
  end

  assign vld_o  = vld_r[FRAC_N];
  assign e_o    = e_r[FRAC_N];
  assign side_o = side_r[FRAC_N];

endmodule
`default_nettype wire

### hw/rtl/distance_rolloff_attenuation.sv
// Distance rolloff attenuation, one sound source per transfer.
// Input channel in_*: one item per transfer, in_tdata holds the source and
// listener positions, near and far limits and rolloff exponent.
// Output channel out_*: distance, attenuation (Q1.16) and range flag.
// Config channel cfg_*: writes the 24-bit noise floor; cfg_ready is always
// high. Write only while no item is in flight.
// The pipeline has 66 register stages; one item is accepted every cycle
// unless the output stalls. The depth comes from the 25-stage square root,
// the 17-stage log2 (normalize plus 16 squaring steps) and the 16-stage
// exp2 product chain.
// Reset clears all valid bits and loads the noise floor reset value.
// When out_tready is low with a result waiting, the whole pipeline holds and
// in_tready drops; nothing is lost or repeated.
`default_nettype none
module distance_rolloff_attenuation
  import dra_pkg::*;
(
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  // source_x, source_y, source_z, listener_x, listener_y, listener_z,
  // near_limit, far_limit, rolloff_exponent
  input  wire logic [207:0]  in_tdata,
  output logic               out_tvalid,
  input  wire logic          out_tready,
  // distance, attenuation, range_flag, zero pad
  output logic [47:0]        out_tdata,
  input  wire logic          cfg_valid,
  output logic               cfg_ready,
  input  wire logic [23:0]   cfg_data
);

  logic            en;
  logic [NF_W-1:0] nf_r;
  logic [40:0]     nf100k_r;

  logic            dv;
  logic [24:0]     dd;
  logic [63:0]     dside;

  logic                  v1_r;
  logic [23:0]           dsat_r;
  logic                  flag_r, gt_r;
  logic [23:0]           xa_r, xb_r;
  logic [ROLL_W-1:0]     r1_r;
  logic [23:0]           near_w, far_w, dsat;
  logic                  flag, gt;

  logic                  lv;
  logic [LOG_W-1:0]      la, lb;
  logic [41:0]           lside;

  logic                  v2_r;
  logic signed [IP_W-1:0] ip2_r;
  logic [15:0]           fp2_r;
  logic [25:0]           s2_r;
  logic signed [21:0]    ldiff;
  logic signed [38:0]    pmul;

  logic                  ev;
  logic [MANT_W-1:0]     ee;
  logic [35:0]           eside;

  logic                  v3_r, v4_r, v5_r;
  logic [40:0]           lo3_r;
  logic [33:0]           hi3_r;
  logic [35:0]           s3_r, s4_r;
  logic [57:0]           prod4_r;
  logic [16:0]           e16;
  logic [23:0]           d5_r;
  logic [ATT_W-1:0]      att5_r;
  logic                  f5_r;
  logic [ATT_W-1:0]      att;
  logic signed [IP_W-1:0] ip4;
  logic signed [IP_W:0]  sh;
  logic [57:0]           shifted;

  assign en        = !v5_r || out_tready;
  assign in_tready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      nf_r <= NF_RESET;
    end else if (cfg_valid) begin
      nf_r <= cfg_data;
    end
    nf100k_r <= nf_r * SCALE;
  end

  dra_dist #(.SW(64)) u_dist (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (in_tvalid),
    .sx     (in_tdata[23:0]),
    .sy     (in_tdata[47:24]),
    .sz     (in_tdata[71:48]),
    .lx     (in_tdata[95:72]),
    .ly     (in_tdata[119:96]),
    .lz     (in_tdata[143:120]),
    .side_i (in_tdata[207:144]),
    .vld_o  (dv),
    .d_o    (dd),
    .side_o (dside)
  );

  assign near_w = dside[23:0];
  assign far_w  = dside[47:24];
  assign dsat   = dd[24] ? D_MAX : dd[23:0];
  assign flag   = dd[24] || (far_w <= near_w);
  assign gt     = dsat > near_w;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en) begin
      v1_r <= dv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dsat_r <= dsat;
      flag_r <= flag;
      gt_r   <= gt;
      xa_r   <= (gt && !flag) ? dsat - near_w : 24'd1;
      xb_r   <= (far_w > near_w) ? far_w - near_w : 24'd1;
      r1_r   <= dside[63:48];
    end
  end

  dra_log #(.SW(42)) u_log (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v1_r),
    .xa_i   (xa_r),
    .xb_i   (xb_r),
    .side_i ({r1_r, gt_r, flag_r, dsat_r}),
    .vld_o  (lv),
    .la_o   (la),
    .lb_o   (lb),
    .side_o (lside)
  );

  assign ldiff = $signed({1'b0, la}) - $signed({1'b0, lb});
  assign pmul  = $signed({1'b0, lside[41:26]}) * ldiff;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en) begin
      v2_r <= lv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ip2_r <= pmul[37:28];
      fp2_r <= pmul[27:12];
      s2_r  <= lside[25:0];
    end
  end

  dra_exp #(.SW(36)) u_exp (
    .clk    (clk),
    .rst_n  (rst_n),
    .en     (en),
    .vld_i  (v2_r),
    .f_i    (fp2_r),
    .side_i ({ip2_r, s2_r}),
    .vld_o  (ev),
    .e_o    (ee),
    .side_o (eside)
  );

  assign e16 = ee[30:14];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v3_r <= ev;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  assign ip4     = s4_r[35:26];
  assign sh      = $signed(11'sd24) - $signed({ip4[IP_W-1], ip4});
  assign shifted = prod4_r >> sh[5:0];

  always_comb begin
    att = '0;
    if (s4_r[25]) begin
      if (s4_r[24]) begin
        att = ONE_Q16;
      end else if (ip4 >= $signed(10'sd24)) begin
        att = (prod4_r != '0) ? ONE_Q16 : '0;
      end else if (sh >= $signed(11'sd64)) begin
        att = '0;
      end else if (shifted > 58'(ONE_Q16)) begin
        att = ONE_Q16;
      end else begin
        att = shifted[ATT_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      lo3_r   <= nf100k_r[23:0] * e16;
      hi3_r   <= nf100k_r[40:24] * e16;
      s3_r    <= eside;
      prod4_r <= {17'd0, lo3_r} + {hi3_r[33:0], 24'd0};
      s4_r    <= s3_r;
      d5_r    <= s4_r[23:0];
      f5_r    <= s4_r[24];
      att5_r  <= att;
    end
  end

  assign out_tvalid = v5_r;
  assign out_tdata  = {6'd0, f5_r, att5_r, d5_r};

`ifndef SYNTHESIS
  a_att_max: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tdata[40:24] <= ONE_Q16))
    else $error("attenuation above one");
  a_flag_att: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tdata[41]) |-> (out_tdata[40:24] == '0 || out_tdata[40:24] == ONE_Q16))
    else $error("flagged item with fractional attenuation");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready == (!out_tvalid || out_tready))
    else $error("input ready does not follow output stall");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tready) |=> out_tvalid)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire
